[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/crclef_pkg.sv]
// Shared types, constants and CRC step function for the log record framer/checker.
package crclef_pkg;

	localparam int ENTRY_BYTES_DEF = 64;
	localparam int MAX_TEXT_DEF    = 61;

	localparam int IDX_W = 7;
	localparam logic [IDX_W-1:0] IDX_MAX = 7'd127;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	localparam logic MODE_FRAME = 1'b0;
	localparam logic MODE_CHECK = 1'b1;

	localparam logic KIND_FRAME   = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	typedef enum logic {
		ST_TAKE,
		ST_TRAIL
	} state_t;

	typedef struct packed {
		logic take;
		logic trail_step;
		logic cfg_wr;
	} cmd_t;

	typedef struct packed {
		logic mode;
		logic out_free;
		logic out_empty;
		logic trail_end;
	} stat_t;

	// one byte into CRC-16/CCITT-FALSE, msb first
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

[hw/rtl/crclef_ctrl.sv]
// Controller: accepts words, sequences the record trailer, gates config writes.
module crclef_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_last,
	input  logic              cfg_valid,
	input  crclef_pkg::stat_t stat,
	output crclef_pkg::cmd_t  cmd,
	output logic              in_stall,
	output logic              cfg_ready
);
	import crclef_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   can_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_TAKE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_TAKE: begin
				if (cmd.take && in_last && stat.mode == MODE_FRAME) begin
					state_d = ST_TRAIL;
				end
			end
			ST_TRAIL: begin
				if (cmd.trail_step && stat.trail_end) begin
					state_d = ST_TAKE;
				end
			end
			default: state_d = ST_TAKE;
		endcase
	end

	always_comb begin
		can_take       = 1'b0;
		cfg_ready      = 1'b0;
		cmd.trail_step = 1'b0;
		case (state_q)
			ST_TAKE: begin
				can_take  = stat.out_free && !cfg_valid;
				cfg_ready = stat.out_empty;
			end
			ST_TRAIL: begin
				cmd.trail_step = stat.out_free;
			end
			default: begin
				can_take = 1'b0;
			end
		endcase
		in_stall   = !can_take;
		cmd.take   = in_valid && can_take;
		cmd.cfg_wr = cfg_valid && cfg_ready;
	end

endmodule

[hw/rtl/crclef_dp.sv]
// Datapath: record state, CRC, trailer byte select and output register.
module crclef_dp #(
	parameter int ENTRY_BYTES = crclef_pkg::ENTRY_BYTES_DEF,
	parameter int MAX_TEXT    = crclef_pkg::MAX_TEXT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  crclef_pkg::cmd_t  cmd,
	output crclef_pkg::stat_t stat,
	input  logic [7:0]        in_byte,
	input  logic              in_last,
	input  logic              mode,
	input  logic              out_stall,
	output logic              out_valid,
	output logic [7:0]        out_byte,
	output logic              out_kind,
	output logic              entry_valid,
	output logic              out_last
);
	import crclef_pkg::*;

	localparam int POS_W      = $clog2(ENTRY_BYTES);
	localparam int TEXT_LIMIT = (MAX_TEXT < ENTRY_BYTES - 3) ? MAX_TEXT : ENTRY_BYTES - 3;
	localparam logic [IDX_W-1:0] LIMIT_I    = IDX_W'(TEXT_LIMIT);
	localparam logic [IDX_W-1:0] TERM_MAX_I = IDX_W'(ENTRY_BYTES - 2);
	localparam logic [IDX_W-1:0] LAST_I     = IDX_W'(ENTRY_BYTES - 1);
	localparam logic [POS_W-1:0] LAST_POS   = POS_W'(ENTRY_BYTES - 1);

	logic             mode_q;
	logic [IDX_W-1:0] idx_q;
	logic [15:0]      crc_q;
	logic             ended_q;
	logic [POS_W-1:0] term_q;
	logic             bad_q;
	logic             done_q;
	logic [POS_W-1:0] pos_q;

	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             out_kind_q;
	logic             entry_valid_q;
	logic             out_last_q;

	logic             zero_b;
	logic [IDX_W-1:0] idx_inc;
	logic [15:0]      crc_in;
	logic [15:0]      crc_term;
	logic             f_emit;
	logic             f_ended_n;
	logic [IDX_W-1:0] f_idx_n;
	logic             c_bad_n;
	logic [15:0]      c_crc_n;
	logic             c_term_hit;
	logic             c_ended_n;
	logic [POS_W-1:0] c_term_n;
	logic             c_done_n;
	logic [IDX_W-1:0] c_idx_n;
	logic             c_ok;
	logic [POS_W-1:0] idx_pos;
	logic             t_at_term;
	logic [7:0]       t_byte;
	logic             t_last;
	logic             out_free;
	logic             ld_out;
	logic [7:0]       ld_byte;
	logic             ld_kind;
	logic             ld_valid;
	logic             ld_last;

	always_comb begin
		zero_b   = (in_byte == 8'h00);
		idx_inc  = idx_q + IDX_W'(1);
		crc_in   = crc_feed(crc_q, in_byte);
		crc_term = crc_feed(crc_q, 8'h00);

		// frame mode
		f_emit    = !ended_q && !zero_b && (idx_q < LIMIT_I);
		f_ended_n = ended_q || zero_b || (idx_inc >= LIMIT_I);
		f_idx_n   = f_emit ? idx_inc : idx_q;

		// check mode
		c_bad_n    = bad_q || (idx_q == '0 && zero_b);
		c_crc_n    = done_q ? crc_q : crc_in;
		c_term_hit = !ended_q && zero_b && (idx_q < TERM_MAX_I);
		c_ended_n  = ended_q || c_term_hit;
		c_term_n   = c_term_hit ? idx_q[POS_W-1:0] : term_q;
		c_done_n   = done_q || (c_ended_n &&
			(idx_q == IDX_W'(c_term_n) + IDX_W'(2)));
		c_idx_n    = (idx_q == IDX_MAX) ? idx_q : idx_inc;
		c_ok       = !c_bad_n && c_ended_n && c_done_n && (c_crc_n == 16'h0000) &&
			(idx_q == LAST_I);

		// trailer: terminator, crc high, crc low, padding
		idx_pos   = idx_q[POS_W-1:0];
		t_at_term = (pos_q == idx_pos);
		if (pos_q == idx_pos + POS_W'(1)) begin
			t_byte = crc_q[15:8];
		end else if (pos_q == idx_pos + POS_W'(2)) begin
			t_byte = crc_q[7:0];
		end else begin
			t_byte = 8'h00;
		end
		t_last = (pos_q == LAST_POS);

		out_free = !out_valid_q || !out_stall;

		ld_out   = 1'b0;
		ld_byte  = 8'h00;
		ld_kind  = KIND_FRAME;
		ld_valid = 1'b0;
		ld_last  = 1'b0;
		if (cmd.trail_step) begin
			ld_out  = 1'b1;
			ld_byte = t_byte;
			ld_last = t_last;
		end else if (cmd.take) begin
			if (mode_q == MODE_CHECK) begin
				ld_out   = in_last;
				ld_kind  = KIND_VERDICT;
				ld_valid = c_ok;
				ld_last  = 1'b1;
			end else begin
				ld_out  = f_emit;
				ld_byte = in_byte;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_FRAME;
			idx_q   <= '0;
			crc_q   <= CRC_INIT;
			ended_q <= 1'b0;
			term_q  <= '0;
			bad_q   <= 1'b0;
			done_q  <= 1'b0;
			pos_q   <= '0;
		end else if (cmd.cfg_wr || (cmd.take && mode_q == MODE_CHECK && in_last) ||
			(cmd.trail_step && t_last)) begin
			if (cmd.cfg_wr) begin
				mode_q <= mode;
			end
			idx_q   <= '0;
			crc_q   <= CRC_INIT;
			ended_q <= 1'b0;
			term_q  <= '0;
			bad_q   <= 1'b0;
			done_q  <= 1'b0;
			pos_q   <= '0;
		end else if (cmd.take) begin
			if (mode_q == MODE_CHECK) begin
				idx_q   <= c_idx_n;
				crc_q   <= c_crc_n;
				ended_q <= c_ended_n;
				term_q  <= c_term_n;
				bad_q   <= c_bad_n;
				done_q  <= c_done_n;
			end else begin
				if (!ended_q) begin
					ended_q <= f_ended_n;
				end
				if (f_emit) begin
					crc_q <= crc_in;
				end
				idx_q <= f_idx_n;
				if (in_last) begin
					pos_q <= f_idx_n[POS_W-1:0];
				end
			end
		end else if (cmd.trail_step) begin
			if (t_at_term) begin
				crc_q <= crc_term;
			end
			pos_q <= pos_q + POS_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_out) begin
			out_byte_q    <= ld_byte;
			out_kind_q    <= ld_kind;
			entry_valid_q <= ld_valid;
			out_last_q    <= ld_last;
		end
	end

	assign stat.mode      = mode_q;
	assign stat.out_free  = out_free;
	assign stat.out_empty = !out_valid_q;
	assign stat.trail_end = t_last;

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign out_kind    = out_kind_q;
	assign entry_valid = entry_valid_q;
	assign out_last    = out_last_q;

endmodule

[hw/rtl/crc16_log_entry_frame_check.sv]
// Top level: CRC-16 log record framer and checker.
//
//  channel | direction | handshake            | payload
//  in      | sink      | in_valid / in_stall  | in_byte, in_last
//  out     | source    | out_valid / out_stall| out_byte, out_kind, entry_valid, out_last
//  cfg     | sink      | cfg_valid / cfg_ready| mode
//
// One input word per cycle in both modes while the output is free and no config write
// is pending; each byte's CRC step is combinational. Frame mode: the word flagged last
// is followed by trailer bytes up to the record end (from n = text bytes kept), with
// in_stall high. A stalled output register holds in_stall high until the word is taken.
// Reset or a mode write returns the record state to its start; no clearing pass.
`include "assert_macros.svh"

module crc16_log_entry_frame_check #(
	parameter int ENTRY_BYTES = crclef_pkg::ENTRY_BYTES_DEF,
	parameter int MAX_TEXT    = crclef_pkg::MAX_TEXT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       out_kind,
	output logic       entry_valid,
	output logic       out_last,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       mode
);
	import crclef_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	crclef_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_last   (in_last),
		.cfg_valid (cfg_valid),
		.stat      (stat),
		.cmd       (cmd),
		.in_stall  (in_stall),
		.cfg_ready (cfg_ready)
	);

	crclef_dp #(
		.ENTRY_BYTES (ENTRY_BYTES),
		.MAX_TEXT    (MAX_TEXT)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.in_byte     (in_byte),
		.in_last     (in_last),
		.mode        (mode),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.out_byte    (out_byte),
		.out_kind    (out_kind),
		.entry_valid (entry_valid),
		.out_last    (out_last)
	);

	`ASSERT_IMPLIES(a_verdict_last, clk, arst_n, out_valid && out_kind == KIND_VERDICT, out_last && out_byte == 8'h00, "verdict word not last or byte nonzero")
	`ASSERT_IMPLIES(a_valid_only_verdict, clk, arst_n, out_valid && entry_valid, out_kind == KIND_VERDICT, "entry_valid on a framed byte")
	`ASSERT_IMPLIES(a_cfg_excl_take, clk, arst_n, cfg_valid && cfg_ready, in_stall && !out_valid, "config write while busy")
	`ASSERT_NEXT(a_trail_blocks, clk, arst_n, in_valid && !in_stall && in_last && stat.mode == MODE_FRAME, in_stall, "input taken during trailer")

endmodule

[bench/tb_crc16_log_entry_frame_check.sv]
`timescale 1ns / 1ps
// Self-checking bench for the CRC-16 log record framer and checker, covering frame and check modes.
module tb_crc16_log_entry_frame_check;
	import crclef_pkg::*;

	localparam int EB = ENTRY_BYTES_DEF;
	localparam int TEXT_LIM = (MAX_TEXT_DEF < EB - 3) ? MAX_TEXT_DEF : EB - 3;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int RANDOM_WORDS = 220;

	typedef struct packed {
		logic [7:0] data;
		logic       kind;
		logic       verdict;
		logic       last;
	} rec_word_t;

	class crc_record_board;
		rec_word_t   expected_q[$];
		int          errors;
		int          taken_words;
		logic        op_mode;
		int          count;
		logic [15:0] crc;
		logic        text_done;
		logic        crc_closed;
		logic        lead_zero;
		int          term_at;

		function new();
			errors = 0;
			taken_words = 0;
			op_mode = MODE_FRAME;
			restart();
		endfunction

		static function logic [15:0] crc_byte(logic [15:0] c, logic [7:0] b);
			logic fb;
			for (int k = 7; k >= 0; k--) begin
				fb = c[15] ^ b[k];
				c = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
			end
			return c;
		endfunction

		function void restart();
			count = 0;
			crc = CRC_INIT;
			text_done = 1'b0;
			crc_closed = 1'b0;
			lead_zero = 1'b0;
			term_at = 0;
		endfunction

		function void set_mode(logic m);
			op_mode = m;
			restart();
		endfunction

		function void queue_word(logic [7:0] d, logic k, logic v, logic l);
			expected_q.push_back({d, k, v, l});
		endfunction

		function void note_word(logic [7:0] d, logic l);
			int          made;
			int          pos;
			logic [15:0] c;
			logic        good;
			made = expected_q.size();
			if (op_mode == MODE_CHECK) begin
				if (count == 0 && d == 8'h00)
					lead_zero = 1'b1;
				if (!crc_closed)
					crc = crc_byte(crc, d);
				if (!text_done && d == 8'h00 && count < EB - 2) begin
					text_done = 1'b1;
					term_at = count;
				end
				if (text_done && count == term_at + 2)
					crc_closed = 1'b1;
				if (l) begin
					good = (!lead_zero && text_done && crc_closed && crc == 16'h0000
						&& count == EB - 1) ? 1'b1 : 1'b0;
					queue_word(8'h00, KIND_VERDICT, good, 1'b1);
					restart();
				end else if (count < int'(IDX_MAX)) begin
					count++;
				end
			end else begin
				if (!text_done) begin
					if (d == 8'h00) begin
						text_done = 1'b1;
					end else if (count < TEXT_LIM) begin
						queue_word(d, KIND_FRAME, 1'b0, 1'b0);
						crc = crc_byte(crc, d);
						count++;
						if (count >= TEXT_LIM)
							text_done = 1'b1;
					end else begin
						text_done = 1'b1;
					end
				end
				if (l) begin
					c = crc_byte(crc, 8'h00);
					queue_word(8'h00, KIND_FRAME, 1'b0, count + 1 >= EB);
					queue_word(c[15:8], KIND_FRAME, 1'b0, count + 2 >= EB);
					queue_word(c[7:0], KIND_FRAME, 1'b0, count + 3 >= EB);
					for (pos = count + 3; pos < EB; pos++)
						queue_word(8'h00, KIND_FRAME, 1'b0, pos + 1 >= EB);
					restart();
				end
			end
			// dropped text bytes do not count as stimulus
			if (op_mode == MODE_CHECK || l || expected_q.size() != made)
				taken_words++;
		endfunction

		function void check_word(rec_word_t got);
			rec_word_t want;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected word: data=%h kind=%b valid=%b last=%b",
					$time, got.data, got.kind, got.verdict, got.last);
				return;
			end
			want = expected_q.pop_front();
			if (want.data !== got.data || want.kind !== got.kind
				|| want.verdict !== got.verdict || want.last !== got.last) begin
				errors++;
				$display("%0t: word mismatch: expected data=%h kind=%b valid=%b last=%b",
					$time, want.data, want.kind, want.verdict, want.last);
				$display("%0t:                actual   data=%h kind=%b valid=%b last=%b",
					$time, got.data, got.kind, got.verdict, got.last);
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] in_byte = 8'h00;
	logic       in_last = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_byte;
	logic       out_kind;
	logic       entry_valid;
	logic       out_last;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic       mode = MODE_FRAME;

	crc_record_board sb;
	logic [7:0] msg_q[$];
	bit         calm = 1'b0;
	bit         long_once = 1'b0;
	int         gap_odds = 0;
	int         stall_left = 0;
	int         cycles = 0;

	crc16_log_entry_frame_check DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_byte(in_byte),
		.in_last(in_last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.out_kind(out_kind),
		.entry_valid(entry_valid),
		.out_last(out_last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.mode(mode)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.set_mode(mode);
			if (in_valid && !in_stall)
				sb.note_word(in_byte, in_last);
			if (out_valid && !out_stall)
				sb.check_word({out_byte, out_kind, entry_valid, out_last});
		end
	end

	// stall bursts alternate with free runs that are short or long
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if (calm) begin
			out_stall <= 1'b0;
		end else if (out_stall) begin
			out_stall <= 1'b0;
			stall_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(20, 200)
				: $urandom_range(0, 19);
		end else begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(0, 18);
		end
	end

	task automatic write_mode(input logic m);
		cfg_valid <= 1'b1;
		mode <= m;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic word_out(input logic [7:0] d, input logic l);
		int gap;
		gap = 0;
		if (!calm && gap_odds != 0 && $urandom_range(0, gap_odds == 1 ? 7 : 2) == 0)
			gap = $urandom_range(1, 19);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= d;
		in_last <= l;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_msg(input bit closed);
		int k;
		gap_odds = $urandom_range(0, 2);
		for (k = 0; k < msg_q.size(); k++)
			word_out(msg_q[k], closed && k == msg_q.size() - 1);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic void fill_random(input int n, input int lo);
		msg_q.delete();
		for (int k = 0; k < n; k++)
			msg_q.push_back(8'($urandom_range(lo, 255)));
	endfunction

	// well-formed record: text, terminator, crc, zero padding
	function automatic void build_record(input int n);
		logic [15:0] c;
		logic [7:0]  d;
		msg_q.delete();
		c = CRC_INIT;
		for (int k = 0; k < n; k++) begin
			d = 8'($urandom_range(1, 255));
			msg_q.push_back(d);
			c = crc_record_board::crc_byte(c, d);
		end
		c = crc_record_board::crc_byte(c, 8'h00);
		msg_q.push_back(8'h00);
		msg_q.push_back(c[15:8]);
		msg_q.push_back(c[7:0]);
		while (msg_q.size() < EB)
			msg_q.push_back(8'h00);
	endfunction

	task automatic frame_message(input int sel);
		case (sel)
			0: fill_random(TEXT_LIM + $urandom_range(0, 4), 1);
			1: begin
				fill_random($urandom_range(2, 8), 1);
				msg_q[$urandom_range(0, msg_q.size() - 1)] = 8'h00;
			end
			2: fill_random($urandom_range(1, 8), 0);
			default: fill_random($urandom_range(1, 6), 1);
		endcase
		send_msg(1'b1);
	endtask

	task automatic check_record(input int sel);
		int n;
		int cut;
		n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, TEXT_LIM) : $urandom_range(1, 8);
		cut = ($urandom_range(0, 3) == 0) ? $urandom_range(1, EB - 1) : $urandom_range(1, 6);
		case (sel)
			1: begin
				// zero only where it no longer counts as terminator
				fill_random(EB - 2, 1);
				msg_q.push_back(8'h00);
				msg_q.push_back(8'($urandom_range(0, 255)));
			end
			2: begin
				build_record(n);
				repeat (long_once ? $urandom_range(1, 6) : EB + 6)
					msg_q.push_back(8'($urandom_range(0, 255)));
				long_once = 1'b1;
			end
			3: begin
				build_record(n);
				msg_q[$urandom_range(0, EB - 1)] ^= 8'($urandom_range(1, 255));
			end
			4: begin
				build_record(n);
				msg_q[0] = 8'h00;
			end
			5, 8, 9: begin
				build_record(n);
				while (msg_q.size() > cut)
					msg_q.pop_back();
			end
			default: build_record(n);
		endcase
		send_msg(1'b1);
	endtask

	initial begin
		int   rand_base;
		int   phase;
		int   frames;
		int   checks;
		logic pick;
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_mode(MODE_FRAME);
		msg_q = {8'h00};
		send_msg(1'b1);
		msg_q = {8'h41};
		send_msg(1'b1);
		msg_q = {8'hFF, 8'h01, 8'h80};
		send_msg(1'b1);
		msg_q = {8'h55, 8'h00, 8'hAA, 8'h7F};
		send_msg(1'b1);
		msg_q = {8'h31, 8'h32};
		send_msg(1'b0);
		settle();
		write_mode(MODE_FRAME);
		msg_q = {8'h33};
		send_msg(1'b1);
		settle();
		write_mode(MODE_CHECK);
		msg_q = {8'h00};
		send_msg(1'b1);
		msg_q = {8'h41, 8'h00, 8'hC3};
		send_msg(1'b1);
		msg_q = {8'h10, 8'h20};
		send_msg(1'b0);
		settle();
		write_mode(MODE_CHECK);

		rand_base = sb.taken_words;
		phase = 0;
		frames = 0;
		checks = 0;
		while (sb.taken_words - rand_base < RANDOM_WORDS) begin
			if (phase < 2)
				pick = (phase == 0) ? MODE_FRAME : MODE_CHECK;
			else
				pick = ($urandom_range(0, 1) == 0) ? MODE_FRAME : MODE_CHECK;
			settle();
			write_mode(pick);
			repeat ($urandom_range(1, 3)) begin
				if (sb.taken_words - rand_base >= RANDOM_WORDS)
					break;
				calm = (sb.taken_words - rand_base > RANDOM_WORDS * 3 / 4);
				if (pick == MODE_FRAME) begin
					frame_message(frames < 4 ? frames : $urandom_range(0, 7));
					frames++;
				end else begin
					check_record(checks < 6 ? checks : $urandom_range(0, 9));
					checks++;
				end
			end
			// leave a record half done so the next mode write restarts it
			if ($urandom_range(0, 4) == 0) begin
				fill_random($urandom_range(1, 4), 0);
				send_msg(1'b0);
			end
			phase++;
		end

		settle();
		repeat (EB + 16) @(posedge clk);
		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
